FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property that also holds across reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/core/lpbp_pkg.sv
package lpbp_pkg;

  // Field widths
  localparam int MAX_VALUE_WIDTH  = 24;
  localparam int LENGTH_FIELD_MAX = 5;
  localparam int VALUE_W   = MAX_VALUE_WIDTH;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(24);

  // Derived widths
  localparam int LEN_W     = $clog2(MAX_VALUE_WIDTH + 1);   // holds a value width
  localparam int LW_W      = $clog2(LENGTH_FIELD_MAX + 1);  // holds a field width
  localparam int CODE_W    = MAX_VALUE_WIDTH + LENGTH_FIELD_MAX;
  localparam int ACC_W     = BYTE_W - 1 + CODE_W;
  localparam int CNT_W     = $clog2(ACC_W + 1);
  localparam int COUNT_CAP = ACC_W - BYTE_W;
  localparam int MAX_RESULTS = 8;
  localparam int RES_W     = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PACK   = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_UNPACK = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_PACK     = 2'd0,
    CMD_PACK_ERR = 2'd1,
    CMD_FLUSH    = 2'd2,
    CMD_UNPACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_PACK   = 2'd1,
    BK_UNPACK = 2'd2
  } bk_state_t;

  // Classified item as it sits in the queue
  typedef struct packed {
    cmd_t              cmd;
    logic [CODE_W-1:0] data;   // code, rejected value or stream byte
    logic [CNT_W-1:0]  clen;   // code length in bits
  } q_entry_t;

  // Clamp the register to the supported value widths
  function automatic logic [LEN_W-1:0] eff_width(input logic [CFG_W-1:0] cfg);
    logic [LEN_W-1:0] w;
    if (cfg == '0) begin
      w = LEN_W'(1);
    end else if (int'(cfg) > MAX_VALUE_WIDTH) begin
      w = LEN_W'(MAX_VALUE_WIDTH);
    end else begin
      w = LEN_W'(cfg);
    end
    return w;
  endfunction

  // Length field width: bits needed to hold the effective width
  function automatic logic [LW_W-1:0] field_width(input logic [LEN_W-1:0] w);
    int bl;
    bl = 0;
    for (int i = 0; i < LEN_W; i++) begin
      if (w[i]) bl = i + 1;
    end
    if (bl > LENGTH_FIELD_MAX) bl = LENGTH_FIELD_MAX;
    return LW_W'(bl);
  endfunction

  // Significant bits of a value
  function automatic logic [LEN_W-1:0] bit_len(input logic [VALUE_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (v[i]) r = LEN_W'(i + 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/lpbp_in_if.sv
interface lpbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpbp_pkg::OP_W-1:0]     operation;
  logic [lpbp_pkg::VALUE_W-1:0]  value_in;
  logic [lpbp_pkg::BYTE_W-1:0]   byte_in;

  modport source (output valid, operation, value_in, byte_in, input ready);
  modport sink   (input valid, operation, value_in, byte_in, output ready);
endinterface

FILE: rtl/core/lpbp_out_if.sv
interface lpbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpbp_pkg::KIND_W-1:0]   kind;
  logic [lpbp_pkg::BYTE_W-1:0]   byte_out;
  logic [lpbp_pkg::VALUE_W-1:0]  value_out;
  logic                          last;

  modport source (output valid, kind, byte_out, value_out, last, input ready);
  modport sink   (input valid, kind, byte_out, value_out, last, output ready);
endinterface

FILE: rtl/core/lpbp_cfg_if.sv
interface lpbp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lpbp_pkg::CFG_W-1:0]   max_value_bits;

  modport source (output valid, max_value_bits, input ready);
  modport sink   (input valid, max_value_bits, output ready);
endinterface

FILE: rtl/core/lpbp_front.sv
module lpbp_front (
  lpbp_in_if.sink                    in_chan,
  input  logic [lpbp_pkg::CFG_W-1:0] cfg_max_bits,
  input  logic                       q_full,
  output logic                       q_push,
  output lpbp_pkg::q_entry_t         q_wdata
);

  logic [lpbp_pkg::LEN_W-1:0]  width;
  logic [lpbp_pkg::LW_W-1:0]   lw;
  logic [lpbp_pkg::LEN_W-1:0]  n;
  logic [lpbp_pkg::CODE_W-1:0] code;

  // Take a word whenever the queue has room; the ignored code is dropped here
  assign in_chan.ready = !q_full;
  assign q_push = in_chan.valid && !q_full &&
                  (lpbp_pkg::op_t'(in_chan.operation) != lpbp_pkg::OP_IGNORE);

  // Build the code: length field, then the value's significant bits
  always_comb begin
    width = lpbp_pkg::eff_width(cfg_max_bits);
    lw    = lpbp_pkg::field_width(width);
    n     = lpbp_pkg::bit_len(in_chan.value_in);
    code  = lpbp_pkg::CODE_W'(n) | (lpbp_pkg::CODE_W'(in_chan.value_in) << lw);
  end

  // Classify the word for the back end
  always_comb begin
    q_wdata.clen = lpbp_pkg::CNT_W'(lw) + lpbp_pkg::CNT_W'(n);
    q_wdata.data = code;
    unique case (lpbp_pkg::op_t'(in_chan.operation))
      lpbp_pkg::OP_PACK: begin
        if (n > width) begin
          q_wdata.cmd  = lpbp_pkg::CMD_PACK_ERR;
          q_wdata.data = lpbp_pkg::CODE_W'(in_chan.value_in);
        end else begin
          q_wdata.cmd  = lpbp_pkg::CMD_PACK;
        end
      end
      lpbp_pkg::OP_FLUSH: begin
        q_wdata.cmd = lpbp_pkg::CMD_FLUSH;
      end
      lpbp_pkg::OP_UNPACK: begin
        q_wdata.cmd  = lpbp_pkg::CMD_UNPACK;
        q_wdata.data = lpbp_pkg::CODE_W'(in_chan.byte_in);
      end
      default: begin
        q_wdata.cmd = lpbp_pkg::CMD_FLUSH;
      end
    endcase
  end

endmodule

FILE: rtl/core/lpbp_queue.sv
module lpbp_queue #(
  parameter int DEPTH = lpbp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpbp_pkg::q_entry_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output lpbp_pkg::q_entry_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lpbp_pkg::q_entry_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold entries; no reset needed on payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/lpbp_back.sv
module lpbp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lpbp_pkg::CFG_W-1:0] cfg_max_bits,
  input  logic                       q_empty,
  input  lpbp_pkg::q_entry_t         q_head,
  output logic                       q_pop,
  lpbp_out_if.source                 out_chan
);

  localparam int ACC_W = lpbp_pkg::ACC_W;
  localparam int CNT_W = lpbp_pkg::CNT_W;
  localparam int NF    = lpbp_pkg::LENGTH_FIELD_MAX;
  localparam int VW    = lpbp_pkg::VALUE_W;
  localparam int BW    = lpbp_pkg::BYTE_W;

  lpbp_pkg::bk_state_t state_r, state_nxt;

  // Packer and unpacker state
  logic [BW-2:0]                  pend_bits_r, pend_bits_nxt;
  logic [2:0]                     pend_cnt_r, pend_cnt_nxt;
  logic [ACC_W-1:0]               uacc_r, uacc_nxt;
  logic [CNT_W-1:0]               ucnt_r, ucnt_nxt;
  logic [lpbp_pkg::RES_W-1:0]     rcnt_r, rcnt_nxt;
  logic [ACC_W-1:0]               wacc_r, wacc_nxt;
  logic [CNT_W-1:0]               wtot_r, wtot_nxt;

  // Output register
  logic                           ov_r, ov_nxt;
  lpbp_pkg::kind_t                okind_r, okind_nxt;
  logic [BW-1:0]                  obyte_r, obyte_nxt;
  logic [VW-1:0]                  ovalue_r, ovalue_nxt;
  logic                           olast_r, olast_nxt;

  logic                           can_emit;
  logic [lpbp_pkg::LEN_W-1:0]     width;
  logic [lpbp_pkg::LW_W-1:0]      lw;
  logic [NF-1:0]                  lw_mask;

  // Load terms
  logic [ACC_W-1:0]               pack_acc;
  logic [CNT_W-1:0]               pack_tot;
  logic [CNT_W-1:0]               cnt0;
  logic [ACC_W-1:0]               acc0;

  // One decode step with a look at the next one
  logic [NF-1:0]                  n1, n2;
  logic                           err1, res1, res2, last1;
  logic [CNT_W-1:0]               use1, cnt1;
  logic [ACC_W-1:0]               acc1, field1;
  logic [VW-1:0]                  vmask, val1;

  assign can_emit = !ov_r || out_chan.ready;

  always_comb begin
    width = lpbp_pkg::eff_width(cfg_max_bits);
    lw    = lpbp_pkg::field_width(width);
    for (int i = 0; i < NF; i++) begin
      lw_mask[i] = (i < int'(lw));
    end
  end

  // Merge a new code or a new byte into the held bits
  always_comb begin
    pack_acc = ACC_W'(pend_bits_r) | (ACC_W'(q_head.data) << pend_cnt_r);
    pack_tot = CNT_W'(pend_cnt_r) + q_head.clen;
    cnt0 = (ucnt_r > CNT_W'(lpbp_pkg::COUNT_CAP)) ? CNT_W'(lpbp_pkg::COUNT_CAP) : ucnt_r;
    acc0 = (uacc_r & ((ACC_W'(1) << cnt0) - ACC_W'(1))) |
           (ACC_W'(q_head.data[BW-1:0]) << cnt0);
  end

  // Decode the code at the bottom of the accumulator
  always_comb begin
    n1    = uacc_r[NF-1:0] & lw_mask;
    err1  = CNT_W'(n1) > CNT_W'(width);
    res1  = (ucnt_r >= CNT_W'(lw)) &&
            (err1 || (ucnt_r >= CNT_W'(lw) + CNT_W'(n1)));
    use1  = err1 ? CNT_W'(lw) : CNT_W'(lw) + CNT_W'(n1);
    for (int i = 0; i < VW; i++) begin
      vmask[i] = (i < int'(n1));
    end
    field1 = uacc_r >> lw;
    val1  = err1 ? VW'(n1) : (field1[VW-1:0] & vmask);
    acc1  = uacc_r >> use1;
    cnt1  = ucnt_r - use1;
    n2    = acc1[NF-1:0] & lw_mask;
    res2  = (cnt1 >= CNT_W'(lw)) &&
            ((CNT_W'(n2) > CNT_W'(width)) || (cnt1 >= CNT_W'(lw) + CNT_W'(n2)));
    last1 = !res2 || (rcnt_r == lpbp_pkg::RES_W'(lpbp_pkg::MAX_RESULTS - 1));
  end

  // Sequencer: take queue entries and emit one result per cycle while the output is not stalled
  always_comb begin
    state_nxt     = state_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    uacc_nxt      = uacc_r;
    ucnt_nxt      = ucnt_r;
    rcnt_nxt      = rcnt_r;
    wacc_nxt      = wacc_r;
    wtot_nxt      = wtot_r;
    q_pop         = 1'b0;
    ov_nxt        = out_chan.ready ? 1'b0 : ov_r;
    okind_nxt     = okind_r;
    obyte_nxt     = obyte_r;
    ovalue_nxt    = ovalue_r;
    olast_nxt     = olast_r;

    unique case (state_r)
      lpbp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.cmd)
            lpbp_pkg::CMD_PACK: begin
              q_pop = 1'b1;
              if (pack_tot >= CNT_W'(BW)) begin
                wacc_nxt  = pack_acc;
                wtot_nxt  = pack_tot;
                state_nxt = lpbp_pkg::BK_PACK;
              end else begin
                pend_bits_nxt = pack_acc[BW-2:0];
                pend_cnt_nxt  = pack_tot[2:0];
              end
            end
            lpbp_pkg::CMD_PACK_ERR: begin
              if (can_emit) begin
                q_pop      = 1'b1;
                ov_nxt     = 1'b1;
                okind_nxt  = lpbp_pkg::KIND_ERROR;
                obyte_nxt  = '0;
                ovalue_nxt = q_head.data[VW-1:0];
                olast_nxt  = 1'b1;
              end
            end
            lpbp_pkg::CMD_FLUSH: begin
              if (pend_cnt_r == '0) begin
                q_pop         = 1'b1;
                pend_bits_nxt = '0;
              end else if (can_emit) begin
                q_pop         = 1'b1;
                ov_nxt        = 1'b1;
                okind_nxt     = lpbp_pkg::KIND_BYTE;
                obyte_nxt     = BW'(pend_bits_r);
                ovalue_nxt    = '0;
                olast_nxt     = 1'b1;
                pend_bits_nxt = '0;
                pend_cnt_nxt  = '0;
              end
            end
            lpbp_pkg::CMD_UNPACK: begin
              q_pop     = 1'b1;
              uacc_nxt  = acc0;
              ucnt_nxt  = cnt0 + CNT_W'(BW);
              rcnt_nxt  = '0;
              state_nxt = lpbp_pkg::BK_UNPACK;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      // Emit completed bytes, keep the remainder as pending bits
      lpbp_pkg::BK_PACK: begin
        if (can_emit) begin
          ov_nxt     = 1'b1;
          okind_nxt  = lpbp_pkg::KIND_BYTE;
          obyte_nxt  = wacc_r[BW-1:0];
          ovalue_nxt = '0;
          olast_nxt  = (wtot_r < CNT_W'(2 * BW));
          wacc_nxt   = wacc_r >> BW;
          wtot_nxt   = wtot_r - CNT_W'(BW);
          if (wtot_r < CNT_W'(2 * BW)) begin
            pend_bits_nxt = wacc_r[2*BW-2:BW];
            pend_cnt_nxt  = wtot_nxt[2:0];
            state_nxt     = lpbp_pkg::BK_IDLE;
          end
        end
      end

      // Emit decoded values and bad lengths until the bits run short or the result limit is hit
      lpbp_pkg::BK_UNPACK: begin
        if (!res1) begin
          state_nxt = lpbp_pkg::BK_IDLE;
        end else if (can_emit) begin
          ov_nxt     = 1'b1;
          okind_nxt  = err1 ? lpbp_pkg::KIND_ERROR : lpbp_pkg::KIND_VALUE;
          obyte_nxt  = '0;
          ovalue_nxt = val1;
          olast_nxt  = last1;
          uacc_nxt   = acc1;
          ucnt_nxt   = cnt1;
          rcnt_nxt   = rcnt_r + 1'b1;
          if (last1) begin
            state_nxt = lpbp_pkg::BK_IDLE;
          end
        end
      end

      default: begin
        state_nxt = lpbp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpbp_pkg::BK_IDLE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      uacc_r      <= '0;
      ucnt_r      <= '0;
      rcnt_r      <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      uacc_r      <= uacc_nxt;
      ucnt_r      <= ucnt_nxt;
      rcnt_r      <= rcnt_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    wacc_r   <= wacc_nxt;
    wtot_r   <= wtot_nxt;
    okind_r  <= okind_nxt;
    obyte_r  <= obyte_nxt;
    ovalue_r <= ovalue_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_chan.valid     = ov_r;
  assign out_chan.kind      = okind_r;
  assign out_chan.byte_out  = obyte_r;
  assign out_chan.value_out = ovalue_r;
  assign out_chan.last      = olast_r;

endmodule

FILE: rtl/core/length_prefixed_bit_packer_top.sv
// Flow: the front end classifies an accepted word into the queue; the back-end sequencer
//   emits a flush or rejected value from idle, a pack or unpack from its own state.
// Throughput: a pack yields up to 4 completed bytes, an unpack up to 8 results; the
//   back-end sequencer emits one result a cycle while the output is not stalled and
//   takes no new entry until done with the last; a 2-entry queue absorbs bursts.
// Reset (rst_n low, synchronous) clears packer, unpacker, queue, output; max_value_bits = 24.
module length_prefixed_bit_packer_top #(
  parameter int QUEUE_DEPTH = lpbp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  lpbp_in_if.sink     in_chan,
  lpbp_out_if.source  out_chan,
  lpbp_cfg_if.sink    cfg_chan
);

  logic [lpbp_pkg::CFG_W-1:0] cfg_max_bits_r;
  logic                       q_push, q_full, q_pop, q_empty;
  lpbp_pkg::q_entry_t         q_wdata, q_head;

  // Configuration register, always ready
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_bits_r <= lpbp_pkg::CFG_RESET;
    end else if (cfg_chan.valid) begin
      cfg_max_bits_r <= cfg_chan.max_value_bits;
    end
  end

  lpbp_front u_front (
    .in_chan      (in_chan),
    .cfg_max_bits (cfg_max_bits_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  lpbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_head)
  );

  lpbp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_max_bits (cfg_max_bits_r),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_chan     (out_chan)
  );

endmodule

FILE: rtl/core/lpbp_checker.sv
`include "assert_macros.svh"

module lpbp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lpbp_pkg::KIND_W-1:0]   out_kind,
  input logic [lpbp_pkg::BYTE_W-1:0]   out_byte,
  input logic [lpbp_pkg::VALUE_W-1:0]  out_value,
  input logic                          out_last
);

  // Hold a stalled result word
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out valid dropped")

  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_kind) && $stable(out_byte) && $stable(out_value) && $stable(out_last), "out word changed while stalled")

  // Unused fields of a result word read as zero
  `ASSERT_CLK(a_field_zero, clk, rst_n, out_valid |-> ((out_kind == lpbp_pkg::KIND_BYTE) ? (out_value == '0) : (out_byte == '0)), "unused result field not zero")

  // Drop any result word across reset
  `ASSERT_CLK_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "out valid after reset")

endmodule

bind length_prefixed_bit_packer_top lpbp_checker u_lpbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.kind),
  .out_byte  (out_chan.byte_out),
  .out_value (out_chan.value_out),
  .out_last  (out_chan.last)
);

FILE: sim/tb_length_prefixed_bit_packer_top.sv
`timescale 1ns / 1ps

module tb_length_prefixed_bit_packer_top;
  import lpbp_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 45;

  typedef struct {
    kind_t              kind;
    logic [BYTE_W-1:0]  byte_val;
    logic [VALUE_W-1:0] value;
    logic               last;
  } codec_result_t;

  logic clk;
  logic rst_n;

  lpbp_in_if  in_bus();
  lpbp_out_if out_bus();
  lpbp_cfg_if cfg_bus();

  length_prefixed_bit_packer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // Predictor state: packer, unpacker and the width register
  logic [6:0]       packed_bits;
  logic [2:0]       packed_cnt;
  logic [35:0]      stream_acc;
  logic [5:0]       stream_cnt;
  logic [CFG_W-1:0] max_bits_reg;

  codec_result_t          expected_results[$];
  logic [BYTE_W-1:0]      packed_stream[$];
  int                     error_count;
  int                     quiet_cycles;
  int                     stall_left;
  bit                     idle_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clamp the register to a usable value width
  function automatic int eff_bits(input logic [CFG_W-1:0] reg_val);
    if (reg_val == '0) return 1;
    if (int'(reg_val) > MAX_VALUE_WIDTH) return MAX_VALUE_WIDTH;
    return int'(reg_val);
  endfunction

  // Work out the results of one accepted word and advance the predictor state
  function automatic void predict_codec(input op_t op, input logic [VALUE_W-1:0] value,
                                        input logic [BYTE_W-1:0] sbyte);
    codec_result_t res[MAX_RESULTS];
    int            nres;
    int            width;
    int            lw;
    int            n;
    int            total;
    int            cnt;
    logic [63:0]   acc;
    nres  = 0;
    width = eff_bits(max_bits_reg);
    lw    = 0;
    for (int i = 0; i < 6; i++) begin
      if (((width >> i) & 1) != 0) lw = i + 1;
    end
    case (op)
      OP_PACK: begin
        n = 0;
        for (int i = 0; i < VALUE_W; i++) begin
          if (value[i]) n = i + 1;
        end
        if (n > width) begin
          res[0] = '{KIND_ERROR, 8'h00, value, 1'b0};
          nres = 1;
        end else begin
          acc = 64'(packed_bits) | ((64'(n) | (64'(value) << lw)) << packed_cnt);
          total = int'(packed_cnt) + lw + n;
          while (total >= 8 && nres < MAX_RESULTS) begin
            res[nres] = '{KIND_BYTE, acc[7:0], '0, 1'b0};
            packed_stream.push_back(acc[7:0]);
            nres++;
            acc = acc >> 8;
            total -= 8;
          end
          packed_bits = acc[6:0];
          packed_cnt  = total[2:0];
        end
      end
      OP_FLUSH: begin
        if (packed_cnt != 0) begin
          res[0] = '{KIND_BYTE, {1'b0, packed_bits}, '0, 1'b0};
          packed_stream.push_back({1'b0, packed_bits});
          nres = 1;
        end
        packed_bits = '0;
        packed_cnt  = '0;
      end
      OP_UNPACK: begin
        cnt = (stream_cnt > 28) ? 28 : int'(stream_cnt);
        acc = 64'(stream_acc) & ((64'd1 << cnt) - 64'd1);
        acc = acc | (64'(sbyte) << cnt);
        cnt += 8;
        while (nres < MAX_RESULTS && cnt >= lw) begin
          n = int'(acc & ((64'd1 << lw) - 64'd1));
          if (n > width) begin
            // bad length: consume only the length field
            res[nres] = '{KIND_ERROR, 8'h00, VALUE_W'(n), 1'b0};
            nres++;
            acc = acc >> lw;
            cnt -= lw;
          end else if (cnt < lw + n) begin
            break;
          end else begin
            res[nres] = '{KIND_VALUE, 8'h00,
                          VALUE_W'((acc >> lw) & ((64'd1 << n) - 64'd1)), 1'b0};
            nres++;
            acc = acc >> (lw + n);
            cnt -= lw + n;
          end
        end
        stream_acc = acc[35:0];
        stream_cnt = cnt[5:0];
      end
      default: ;
    endcase
    if (nres > 0) res[nres-1].last = 1'b1;
    for (int i = 0; i < nres; i++) expected_results.push_back(res[i]);
  endfunction

  // Monitor: check results, predict accepted words, track the register, watchdog
  always @(posedge clk) begin
    codec_result_t exp_res;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %h value %h last %b", $time,
                   out_bus.kind, out_bus.byte_out, out_bus.value_out, out_bus.last);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_bus.kind !== exp_res.kind || out_bus.byte_out !== exp_res.byte_val ||
              out_bus.value_out !== exp_res.value || out_bus.last !== exp_res.last) begin
            $display("%0t: mismatch expected kind %0d byte %h value %h last %b", $time,
                     exp_res.kind, exp_res.byte_val, exp_res.value, exp_res.last);
            $display("%0t:          actual   kind %0d byte %h value %h last %b", $time,
                     out_bus.kind, out_bus.byte_out, out_bus.value_out, out_bus.last);
            error_count++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready)
        predict_codec(op_t'(in_bus.operation), in_bus.value_in, in_bus.byte_in);
      if (cfg_bus.valid && cfg_bus.ready)
        max_bits_reg = cfg_bus.max_value_bits;
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("length_prefixed_bit_packer_top verification failed");
        $finish;
      end
    end
  end

  // Result side: stall in random bursts while idling is on
  initial begin
    out_bus.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Send one word; with from_stream, take the byte from the packed stream if any
  task automatic send_word(input op_t op, input logic [VALUE_W-1:0] value,
                           input logic [BYTE_W-1:0] sbyte, input bit from_stream);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (from_stream && packed_stream.size() > 0) sbyte = packed_stream.pop_front();
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.value_in  <= value;
    in_bus.byte_in   <= sbyte;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the block go quiet
  task automatic settle_codec();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the width register; the block must be idle
  task automatic write_max_bits(input logic [CFG_W-1:0] bits);
    settle_codec();
    @(negedge clk);
    cfg_bus.valid          <= 1'b1;
    cfg_bus.max_value_bits <= bits;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random value with exactly n significant bits
  function automatic logic [VALUE_W-1:0] value_of_length(input int n);
    logic [VALUE_W-1:0] v;
    if (n == 0) return '0;
    v = VALUE_W'($urandom) & ((VALUE_W'(1) << (n - 1)) - VALUE_W'(1));
    return v | (VALUE_W'(1) << (n - 1));
  endfunction

  // Pack the extremes at reset width, then flush with and without pending bits
  task automatic test_pack_extremes();
    send_word(OP_PACK, 24'h000000, 8'h00, 1'b0);
    send_word(OP_PACK, 24'h000001, 8'h00, 1'b0);
    send_word(OP_PACK, 24'hFFFFFF, 8'h00, 1'b0);
    send_word(OP_PACK, 24'h800000, 8'h00, 1'b0);
    send_word(OP_PACK, 24'h5A5A5A, 8'h00, 1'b0);
    send_word(OP_FLUSH, 24'h000000, 8'h00, 1'b0);
    send_word(OP_FLUSH, 24'hFFFFFF, 8'hFF, 1'b0);
    send_word(OP_IGNORE, 24'hFFFFFF, 8'hFF, 1'b0);
  endtask

  // Bad length, incomplete code held over, zero padding decoding as zeros
  task automatic test_unpack_cases();
    send_word(OP_UNPACK, 24'h000000, 8'hFF, 1'b0);
    send_word(OP_UNPACK, 24'h000000, 8'h00, 1'b0);
    send_word(OP_UNPACK, 24'h000000, 8'h00, 1'b0);
    send_word(OP_UNPACK, 24'hFFFFFF, 8'hAA, 1'b0);
  endtask

  // Register zero acts as one, values too wide are rejected, top values clamp
  task automatic test_width_limits();
    write_max_bits(5'd0);
    send_word(OP_PACK, 24'h000002, 8'h00, 1'b0);
    send_word(OP_PACK, 24'h000001, 8'h00, 1'b0);
    send_word(OP_PACK, 24'h000000, 8'h00, 1'b0);
    send_word(OP_FLUSH, 24'h000000, 8'h00, 1'b0);
    send_word(OP_UNPACK, 24'h000000, 8'hFF, 1'b0);
    send_word(OP_UNPACK, 24'h000000, 8'h00, 1'b0);
    write_max_bits(5'd31);
    send_word(OP_PACK, 24'hFFFFFF, 8'h00, 1'b0);
    send_word(OP_FLUSH, 24'h000000, 8'h00, 1'b0);
  endtask

  // Random phase: mostly packed words looped back into the unpacker
  task automatic test_random_stream(input logic [CFG_W-1:0] bits, input int words);
    int width;
    int pick;
    write_max_bits(bits);
    width = eff_bits(bits);
    for (int i = 0; i < words; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word(OP_PACK, value_of_length($urandom_range(0, width)), 8'($urandom), 1'b0);
      end else if (pick < 50) begin
        if (width < MAX_VALUE_WIDTH)
          send_word(OP_PACK, value_of_length($urandom_range(width + 1, MAX_VALUE_WIDTH)),
                    8'($urandom), 1'b0);
        else
          send_word(OP_PACK, VALUE_W'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 58) begin
        send_word(OP_FLUSH, VALUE_W'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 92) begin
        send_word(OP_UNPACK, VALUE_W'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 97) begin
        send_word(OP_UNPACK, VALUE_W'($urandom), 8'($urandom), 1'b0);
      end else begin
        send_word(OP_IGNORE, VALUE_W'($urandom), 8'($urandom), 1'b0);
      end
    end
    // close the phase so the stream ends on a byte boundary
    send_word(OP_FLUSH, '0, '0, 1'b0);
  endtask

  // Stimulus
  initial begin
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.operation       = OP_PACK;
    in_bus.value_in        = '0;
    in_bus.byte_in         = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.max_value_bits = CFG_RESET;
    packed_bits            = '0;
    packed_cnt             = '0;
    stream_acc             = '0;
    stream_cnt             = '0;
    max_bits_reg           = CFG_RESET;
    error_count            = 0;
    quiet_cycles           = 0;
    idle_on                = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_pack_extremes();
    test_unpack_cases();
    test_width_limits();

    test_random_stream(5'd24, RANDOM_WORDS);
    test_random_stream(5'd1, RANDOM_WORDS);
    test_random_stream(5'd5, RANDOM_WORDS);
    test_random_stream(5'd16, RANDOM_WORDS);
    test_random_stream(5'd31, RANDOM_WORDS);
    test_random_stream(5'd0, RANDOM_WORDS);
    test_random_stream(5'd8, RANDOM_WORDS);
    test_random_stream(5'd3, RANDOM_WORDS);
    settle_codec();
    idle_on = 1'b0;
    test_random_stream(5'd24, RANDOM_WORDS);

    settle_codec();
    if (error_count == 0) begin
      $display("length_prefixed_bit_packer_top verification clean");
    end else begin
      $display("length_prefixed_bit_packer_top verification failed");
    end
    $finish;
  end

endmodule
